// File: hw/rtl/lsefd_pkg.sv
package lsefd_pkg;

  // weight table select codes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_STRAIGHT = 2'd1;
  localparam logic [1:0] MODE_LEFT     = 2'd2;

  localparam int NUM_SENSORS = 8;

  // reciprocal scale: quotient estimate is (num * recip) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 23;
  localparam int NUM_W       = 17;  // |sum| << 8
  localparam int RECIP_W     = 20;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int QUOT_W      = 10;  // quotient never exceeds 896
  localparam int DIV_W       = 7;   // 10 * count, at most 70

  // weights in tenths of a sensor pitch, sensor 0 first
  localparam logic signed [6:0] W_NORMAL [NUM_SENSORS] = '{
    -7'sd35, -7'sd25, -7'sd15, -7'sd5, 7'sd5, 7'sd15, 7'sd25, 7'sd35};
  localparam logic signed [6:0] W_STRAIGHT [NUM_SENSORS] = '{
    -7'sd5, -7'sd4, -7'sd3, -7'sd2, 7'sd5, 7'sd15, 7'sd25, 7'sd35};
  localparam logic signed [6:0] W_LEFT [NUM_SENSORS] = '{
    -7'sd35, -7'sd25, -7'sd15, -7'sd5, 7'sd2, 7'sd3, 7'sd4, 7'sd5};

  // per-result flags carried down the pipe
  typedef struct packed {
    logic [3:0] black_count;
    logic       middle_all_black;
    logic       fork_split;
    logic       straight_passed;
    logic       left_passed;
    logic       narrow_line;
  } lsefd_flags_t;

  // after decode
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic             neg;
    logic             zero;
    logic [2:0]       cnt;
    lsefd_flags_t     flags;
  } lsefd_dec_t;

  // after quotient correction
  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              neg;
    logic              zero;
    lsefd_flags_t      flags;
  } lsefd_quot_t;

  function automatic logic signed [6:0] weight(input logic [1:0] mode,
                                               input logic [2:0] idx);
    logic signed [6:0] w;
    unique case (mode)
      MODE_STRAIGHT: w = W_STRAIGHT[idx];
      MODE_LEFT:     w = W_LEFT[idx];
      default:       w = W_NORMAL[idx];
    endcase
    return w;
  endfunction

  // floor(2^23 / (10 * cnt)); estimate is exact or one low
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      3'd1:    r = 20'd838860;
      3'd2:    r = 20'd419430;
      3'd3:    r = 20'd279620;
      3'd4:    r = 20'd209715;
      3'd5:    r = 20'd167772;
      3'd6:    r = 20'd139810;
      3'd7:    r = 20'd119837;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DIV_W-1:0] divisor(input logic [2:0] cnt);
    logic [DIV_W-1:0] d;
    unique case (cnt)
      3'd1:    d = 7'd10;
      3'd2:    d = 7'd20;
      3'd3:    d = 7'd30;
      3'd4:    d = 7'd40;
      3'd5:    d = 7'd50;
      3'd6:    d = 7'd60;
      3'd7:    d = 7'd70;
      default: d = 7'd10;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/lsefd_decode.sv
module lsefd_decode import lsefd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] fork_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_sensor_bits,
  output logic       dn_valid,
  input  logic       dn_ready,
  output lsefd_dec_t dn_data
);

  logic       valid_r;
  lsefd_dec_t data_r;
  lsefd_dec_t data_nxt;

  logic signed [9:0] sum;
  logic [8:0]        mag;
  logic [3:0]        cnt;
  logic [2:0]        lo_blk_cnt;
  logic [2:0]        hi_blk_cnt;
  logic [7:0]        blk;

  // weighted sum and black counts
  always_comb begin
    blk        = ~in_sensor_bits;
    sum        = '0;
    cnt        = '0;
    lo_blk_cnt = '0;
    hi_blk_cnt = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (blk[i]) begin
        sum = sum + 10'(weight(fork_mode, 3'(i)));
        cnt = cnt + 4'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      lo_blk_cnt = lo_blk_cnt + {2'b00, blk[i]};
    end
    for (int i = 4; i < 8; i++) begin
      hi_blk_cnt = hi_blk_cnt + {2'b00, blk[i]};
    end
  end

  // magnitude, sign and pattern flags
  always_comb begin
    mag                               = sum[9] ? 9'(-sum) : sum[8:0];
    data_nxt.num                      = {mag, 8'h00};
    data_nxt.neg                      = sum[9];
    data_nxt.zero                     = (cnt == 4'd0) || (cnt == 4'd8);
    data_nxt.cnt                      = cnt[2:0];
    data_nxt.flags.black_count        = cnt;
    data_nxt.flags.middle_all_black   = (in_sensor_bits & 8'h7E) == 8'h00;
    data_nxt.flags.fork_split         = in_sensor_bits[3] & blk[2] & blk[4];
    data_nxt.flags.straight_passed    = (in_sensor_bits[2:0] == 3'b111) &&
                                        (hi_blk_cnt == 3'd1 || hi_blk_cnt == 3'd2);
    data_nxt.flags.left_passed        = (in_sensor_bits[7:4] == 4'hF) &&
                                        (lo_blk_cnt == 3'd1 || lo_blk_cnt == 3'd2);
    data_nxt.flags.narrow_line        = (cnt >= 4'd1) && (cnt <= 4'd3);
  end

  assign in_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: hw/rtl/lsefd_recip_div.sv
module lsefd_recip_div import lsefd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  lsefd_dec_t  up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output lsefd_quot_t dn_data
);

  // stage A: reciprocal multiply
  logic              a_valid_r;
  logic              a_ready;
  logic [PROD_W-1:0] a_prod_r;
  logic [NUM_W-1:0]  a_num_r;
  logic [DIV_W-1:0]  a_div_r;
  logic              a_neg_r;
  logic              a_zero_r;
  lsefd_flags_t      a_flags_r;

  // stage B: one-step correction
  logic              b_valid_r;
  logic              b_ready;
  lsefd_quot_t       b_data_r;

  logic [QUOT_W-1:0] q_est;
  logic [NUM_W:0]    back_prod;
  logic [NUM_W:0]    rem;
  logic              bump;

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_prod_r  <= PROD_W'(up_data.num) * PROD_W'(recip(up_data.cnt));
      a_num_r   <= up_data.num;
      a_div_r   <= divisor(up_data.cnt);
      a_neg_r   <= up_data.neg;
      a_zero_r  <= up_data.zero;
      a_flags_r <= up_data.flags;
    end
  end

  // estimate is the true quotient or one below it
  always_comb begin
    q_est     = a_prod_r[RECIP_SHIFT +: QUOT_W];
    back_prod = (NUM_W+1)'(q_est) * (NUM_W+1)'(a_div_r);
    rem       = {1'b0, a_num_r} - back_prod;
    bump      = rem >= (NUM_W+1)'(a_div_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_data_r.quot  <= q_est + QUOT_W'(bump);
      b_data_r.neg   <= a_neg_r;
      b_data_r.zero  <= a_zero_r;
      b_data_r.flags <= a_flags_r;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data  = b_data_r;

endmodule

// File: hw/rtl/line_sensor_error_and_fork_detect_top.sv
// Line sensor centroid and fork detector. Each request carries one 8-bit sample
// (bit clear = sensor over black); the result gives the mean weight of the black
// sensors as a signed error in 1/256 sensor pitch, truncated toward zero, plus the
// black count and the fork pattern flags. The weight table comes from cfg_wr_data
// (0 normal, 1 straight branch, 2 left branch, 3 acts as normal), written while
// idle. Throughput is one sample per clock while out_ready is high. The edge that
// accepts a request loads the decode and weighted-sum stage; the request then moves
// through reciprocal multiply, quotient correction and the signed output register,
// and out_valid rises once it is in the output register. Backpressure on out_ready
// stalls the full stages without losing or repeating a request.
module line_sensor_error_and_fork_detect_top import lsefd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_sensor_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [10:0] out_line_error,
  output logic [3:0]         out_black_count,
  output logic               out_middle_all_black,
  output logic               out_fork_split,
  output logic               out_straight_passed,
  output logic               out_left_passed,
  output logic               out_narrow_line
);

  logic [1:0]         fork_mode_r;
  logic               dec_valid;
  logic               dec_ready;
  lsefd_dec_t         dec_data;
  logic               quot_valid;
  logic               quot_ready;
  lsefd_quot_t        quot_data;
  logic               out_valid_r;
  logic signed [10:0] err_r;
  logic signed [10:0] err_nxt;
  lsefd_flags_t       flags_r;
  logic [10:0]        mag;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fork_mode_r <= MODE_NORMAL;
    end else if (cfg_wr_en) begin
      fork_mode_r <= cfg_wr_data;
    end
  end

  lsefd_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .fork_mode      (fork_mode_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sensor_bits (in_sensor_bits),
    .dn_valid       (dec_valid),
    .dn_ready       (dec_ready),
    .dn_data        (dec_data)
  );

  lsefd_recip_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (quot_valid),
    .dn_ready (quot_ready),
    .dn_data  (quot_data)
  );

  // apply sign; no black or all black gives zero error
  always_comb begin
    mag = {1'b0, quot_data.quot};
    if (quot_data.zero) begin
      err_nxt = '0;
    end else if (quot_data.neg) begin
      err_nxt = -$signed(mag);
    end else begin
      err_nxt = $signed(mag);
    end
  end

  // output register
  assign quot_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (quot_ready) begin
      out_valid_r <= quot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quot_ready && quot_valid) begin
      err_r   <= err_nxt;
      flags_r <= quot_data.flags;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_line_error       = err_r;
  assign out_black_count      = flags_r.black_count;
  assign out_middle_all_black = flags_r.middle_all_black;
  assign out_fork_split       = flags_r.fork_split;
  assign out_straight_passed  = flags_r.straight_passed;
  assign out_left_passed      = flags_r.left_passed;
  assign out_narrow_line      = flags_r.narrow_line;

`ifndef ASSERT_OFF
  // input only blocks when every stage is full and the sink stalls
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while pipeline has room");

  a_zero_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_black_count == 4'd0 || out_black_count == 4'd8)
      |-> out_line_error == 11'sd0)
    else $error("nonzero error with no or all sensors black");

  a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_error <= 11'sd896 && out_line_error >= -11'sd896))
    else $error("line error out of range");

  a_narrow_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_narrow_line |-> (out_black_count >= 4'd1 && out_black_count <= 4'd3))
    else $error("narrow line flag disagrees with black count");

  a_middle_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_middle_all_black |-> out_black_count >= 4'd6)
    else $error("middle all black with fewer than six black");
`endif

endmodule

// File: tb/tb_line_sensor_error_and_fork_detect_top.sv
module tb_line_sensor_error_and_fork_detect_top import lsefd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // code 3 is not a table of its own, the block treats it as normal
  localparam logic [1:0] MODE_NORMAL_ALIAS = 2'd3;

  localparam int MAX_GAP        = 12;
  localparam int LATENCY        = 4;
  localparam int LONG_HOLD      = 80;
  localparam int RANDOM_PER_MODE = 450;
  localparam int CYCLE_LIMIT    = 400000;

  // tenths of a sensor pitch, sensor 0 first
  localparam int NORMAL_TENTHS [8]   = '{-35, -25, -15, -5, 5, 15, 25, 35};
  localparam int STRAIGHT_TENTHS [8] = '{-5, -4, -3, -2, 5, 15, 25, 35};
  localparam int LEFT_TENTHS [8]     = '{-35, -25, -15, -5, 2, 3, 4, 5};

  typedef struct {
    logic signed [10:0] line_error;
    logic [3:0]         black_count;
    logic               middle_all_black;
    logic               fork_split;
    logic               straight_passed;
    logic               left_passed;
    logic               narrow_line;
  } centroid_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [1:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_sensor_bits;
  logic               out_valid;
  logic               out_ready;
  logic signed [10:0] out_line_error;
  logic [3:0]         out_black_count;
  logic               out_middle_all_black;
  logic               out_fork_split;
  logic               out_straight_passed;
  logic               out_left_passed;
  logic               out_narrow_line;

  centroid_result_t pending_results [$];
  logic [1:0]       table_mode;
  bit               burst_mode;
  bit               long_hold_req;
  int               error_count;
  int               samples_sent;
  int               results_checked;
  int               mode_writes;
  int               fork_hits;
  int               straight_hits;
  int               left_hits;
  int               cycle_count;

  line_sensor_error_and_fork_detect_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sensor_bits       (in_sensor_bits),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_line_error       (out_line_error),
    .out_black_count      (out_black_count),
    .out_middle_all_black (out_middle_all_black),
    .out_fork_split       (out_fork_split),
    .out_straight_passed  (out_straight_passed),
    .out_left_passed      (out_left_passed),
    .out_narrow_line      (out_narrow_line)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // weighted centroid and fork flags for one sample under one table
  function automatic centroid_result_t predict_centroid(input logic [7:0] bits,
                                                       input logic [1:0] mode);
    centroid_result_t r;
    int               sum;
    int               cnt;
    int               hi_blk_cnt;
    int               lo_blk_cnt;
    int               w;
    sum = 0;
    cnt = 0;
    hi_blk_cnt = 0;
    lo_blk_cnt = 0;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        MODE_STRAIGHT: w = STRAIGHT_TENTHS[i];
        MODE_LEFT:     w = LEFT_TENTHS[i];
        default:       w = NORMAL_TENTHS[i];
      endcase
      if (!bits[i]) begin
        sum += w;
        cnt++;
        if (i >= 4) hi_blk_cnt++;
        if (i <= 2) lo_blk_cnt++;
      end
    end
    // SV integer division truncates toward zero
    r.line_error = (cnt == 0 || cnt == 8) ? 11'sd0 : 11'((sum * 256) / (10 * cnt));
    r.black_count = 4'(cnt);
    r.middle_all_black = (bits[6:1] == 6'b0);
    r.fork_split = bits[3] && !bits[2] && !bits[4];
    r.straight_passed = (bits[2:0] == 3'b111) && hi_blk_cnt >= 1 && hi_blk_cnt <= 2;
    r.left_passed = (bits[7:4] == 4'hF) && lo_blk_cnt >= 1 && lo_blk_cnt <= 2;
    r.narrow_line = cnt >= 1 && cnt <= 3;
    return r;
  endfunction

  // mix of uniform samples, thin lines on white and wide black areas
  function automatic logic [7:0] draw_sample();
    logic [7:0] s;
    case ($urandom_range(0, 3))
      0, 1: s = 8'($urandom);
      2: begin
        s = 8'hFF;
        repeat ($urandom_range(1, 3)) s[$urandom_range(0, 7)] = 1'b0;
      end
      default: begin
        s = 8'h00;
        repeat ($urandom_range(0, 2)) s[$urandom_range(0, 7)] = 1'b1;
      end
    endcase
    return s;
  endfunction

  // offer one request after a random gap (none in burst mode), return at its acceptance edge
  task automatic push_sample(input logic [7:0] bits);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sensor_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_centroid(bits, table_mode));
    samples_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender idle until every expected result is back
  task automatic wait_results_done();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // table select is only changed with the pipe empty
  task automatic write_fork_mode(input logic [1:0] mode);
    wait_results_done();
    repeat (LATENCY + 2) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    table_mode = mode;
    mode_writes++;
  endtask

  // receiver: random stall per result, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      int stall;
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      stall = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    centroid_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: line_error %0d", out_line_error);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (out_line_error !== exp_r.line_error) begin
          $error("line_error expected %0d got %0d", exp_r.line_error, out_line_error);
          error_count++;
        end
        if (out_black_count !== exp_r.black_count) begin
          $error("black_count expected %0d got %0d", exp_r.black_count, out_black_count);
          error_count++;
        end
        if (out_middle_all_black !== exp_r.middle_all_black) begin
          $error("middle_all_black expected %0b got %0b", exp_r.middle_all_black,
                 out_middle_all_black);
          error_count++;
        end
        if (out_fork_split !== exp_r.fork_split) begin
          $error("fork_split expected %0b got %0b", exp_r.fork_split, out_fork_split);
          error_count++;
        end
        if (out_straight_passed !== exp_r.straight_passed) begin
          $error("straight_passed expected %0b got %0b", exp_r.straight_passed,
                 out_straight_passed);
          error_count++;
        end
        if (out_left_passed !== exp_r.left_passed) begin
          $error("left_passed expected %0b got %0b", exp_r.left_passed, out_left_passed);
          error_count++;
        end
        if (out_narrow_line !== exp_r.narrow_line) begin
          $error("narrow_line expected %0b got %0b", exp_r.narrow_line, out_narrow_line);
          error_count++;
        end
        fork_hits += exp_r.fork_split;
        straight_hits += exp_r.straight_passed;
        left_hits += exp_r.left_passed;
      end
    end
  end

  // extremes, every flag pattern, then single-sided lines under each table
  task automatic test_directed_patterns();
    logic [7:0] reset_set [12] = '{8'h00, 8'hFF, 8'hFE, 8'h7F, 8'h81, 8'hEB,
                                  8'hEF, 8'h9F, 8'hFC, 8'hF8, 8'hF1, 8'h55};
    logic [7:0] table_set [4] = '{8'hFE, 8'h7F, 8'h0F, 8'hF0};
    logic [1:0] modes [3] = '{MODE_STRAIGHT, MODE_LEFT, MODE_NORMAL_ALIAS};
    // reset value of the table select is normal
    foreach (reset_set[i]) push_sample(reset_set[i]);
    foreach (modes[m]) begin
      write_fork_mode(modes[m]);
      foreach (table_set[i]) push_sample(table_set[i]);
    end
  endtask

  // random samples under every table, with stretches of full rate
  task automatic test_random_tables();
    logic [1:0] modes [5] = '{MODE_NORMAL, MODE_LEFT, MODE_STRAIGHT, MODE_NORMAL_ALIAS,
                              MODE_NORMAL};
    foreach (modes[m]) begin
      write_fork_mode(modes[m]);
      for (int i = 0; i < RANDOM_PER_MODE * (m == 4 ? 0 : 1); i++) begin
        burst_mode = ((i / 50) % 4) == 3;
        push_sample(draw_sample());
      end
      burst_mode = 1'b0;
    end
  endtask

  // receiver holds off while requests keep coming, so the pipe backs up
  task automatic test_output_backpressure();
    write_fork_mode(MODE_STRAIGHT);
    long_hold_req = 1'b1;
    burst_mode = 1'b1;
    repeat (40) push_sample(draw_sample());
    burst_mode = 1'b0;
    repeat (20) push_sample(draw_sample());
  endtask

  // sender goes quiet until the pipe has drained, then resumes
  task automatic test_input_pause();
    write_fork_mode(MODE_LEFT);
    repeat (30) push_sample(draw_sample());
    wait_results_done();
    repeat (30) push_sample(draw_sample());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = MODE_NORMAL;
    in_valid = 1'b0;
    in_sensor_bits = 8'h00;
    table_mode = MODE_NORMAL;
    burst_mode = 1'b0;
    long_hold_req = 1'b0;
    error_count = 0;
    samples_sent = 0;
    results_checked = 0;
    mode_writes = 0;
    fork_hits = 0;
    straight_hits = 0;
    left_hits = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_patterns();
    test_random_tables();
    test_output_backpressure();
    test_input_pause();

    wait_results_done();
    repeat (LATENCY * 4) @(negedge clk);
    $display("Checked %0d of %0d samples across %0d table selects (incl. code 3).",
             results_checked, samples_sent, mode_writes);
    $display("Fork flags seen: split %0d, straight passed %0d, left passed %0d.",
             fork_hits, straight_hits, left_hits);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
